FILE: rtl/pcs_pkg.sv
package pcs_pkg;

  localparam int WORD_W  = 64;
  localparam int MEAN_W  = 16;
  localparam int SD_W    = 16;
  localparam int COV_W   = 32;
  localparam int CORR_W  = 16;
  localparam int COUNT_W = 11;
  localparam int ROOT_W  = 32;
  localparam int ITER_W  = 6;

  localparam logic [WORD_W-1:0] CORR_ONE = WORD_W'(16384);
  localparam int CORR_SHIFT = 14;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_t;

  // One step of the end-of-set sequence.
  typedef enum logic [3:0] {
    ST_NXX, ST_SXX, ST_NYY, ST_SYY, ST_NXY, ST_SXY,
    ST_MX, ST_MY, ST_VX, ST_RX, ST_VY, ST_RY,
    ST_CV, ST_PD, ST_CR
  } step_t;

  typedef struct packed {
    logic  accept;
    logic  begin_set;
    logic  start;
    step_t step;
    logic  load_out;
  } pcs_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic n_zero;
    logic dev_zero;
  } pcs_status_t;

endpackage

FILE: rtl/pcs_arith.sv
module pcs_arith
  import pcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  arith_op_t op,
  input  word_t     opa,
  input  word_t     opb,
  output word_t     result,
  output logic      done
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  arith_op_t         op_r, op_nxt;
  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  word_t             c_r, c_nxt;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  word_t             trial;
  logic [ITER_W-1:0] last_iter;

  assign shifted   = {a_r, b_r[WORD_W-1]};
  assign diff      = shifted - {1'b0, c_r};
  assign trial     = b_r + c_r;
  assign last_iter = (op_r == ARITH_SQRT) ? ITER_W'(ROOT_W - 1) : ITER_W'(WORD_W - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      op_nxt   = op;
      case (op)
        ARITH_MUL: begin
          a_nxt = '0;
          b_nxt = opa;
          c_nxt = opb;
        end
        ARITH_DIV: begin
          a_nxt = '0;
          b_nxt = opa;
          c_nxt = opb;
        end
        ARITH_SQRT: begin
          a_nxt = opa;
          b_nxt = '0;
          c_nxt = word_t'(1) << (WORD_W - 2);
        end
        default: begin
          a_nxt = '0;
          b_nxt = '0;
          c_nxt = '0;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        ARITH_MUL: begin
          a_nxt = c_r[0] ? a_r + b_r : a_r;
          b_nxt = b_r << 1;
          c_nxt = c_r >> 1;
        end
        ARITH_DIV: begin
          if (!diff[WORD_W]) begin
            a_nxt = diff[WORD_W-1:0];
            b_nxt = {b_r[WORD_W-2:0], 1'b1};
          end else begin
            a_nxt = shifted[WORD_W-1:0];
            b_nxt = {b_r[WORD_W-2:0], 1'b0};
          end
        end
        ARITH_SQRT: begin
          if (a_r >= trial) begin
            a_nxt = a_r - trial;
            b_nxt = (b_r >> 1) + c_r;
          end else begin
            b_nxt = b_r >> 1;
          end
          c_nxt = c_r >> 2;
        end
        default: begin
          a_nxt = a_r;
        end
      endcase
      iter_nxt = iter_r + ITER_W'(1);
      if (iter_r == last_iter) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    iter_r <= iter_nxt;
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
  end

  always_comb begin
    case (op_r)
      ARITH_MUL:  result = a_r;
      ARITH_DIV:  result = (c_r == '0) ? '0 : b_r;
      ARITH_SQRT: result = b_r;
      default:    result = '0;
    endcase
  end

  assign done = done_r;

endmodule

FILE: rtl/pcs_datapath.sv
module pcs_datapath
  import pcs_pkg::*;
#(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcs_cmd_t                      cmd,
  output pcs_status_t                   status,
  input  logic signed [SAMPLE_BITS-1:0] sample_x,
  input  logic signed [SAMPLE_BITS-1:0] sample_y,
  output logic signed [MEAN_W-1:0]      mean_x,
  output logic signed [MEAN_W-1:0]      mean_y,
  output logic [SD_W-1:0]               std_dev_x,
  output logic [SD_W-1:0]               std_dev_y,
  output logic signed [COV_W-1:0]       covariance_xy,
  output logic signed [CORR_W-1:0]      correlation,
  output logic [COUNT_W-1:0]            pair_count,
  output logic                          stats_error
);

  localparam int CW    = $clog2(MAX_PAIRS + 1);
  localparam int PW    = 2 * SAMPLE_BITS;
  localparam int XW_F  = SAMPLE_BITS + $clog2(MAX_PAIRS);
  localparam int SW_F  = PW + $clog2(MAX_PAIRS);
  localparam int XW    = (XW_F > WORD_W) ? WORD_W : XW_F;
  localparam int SW    = (SW_F > WORD_W) ? WORD_W : SW_F;

  // Accumulation: products are registered, then summed the next cycle.
  logic signed [PW-1:0] pxx_r, pyy_r, pxy_r;
  logic signed [SAMPLE_BITS-1:0] px_r, py_r;
  logic                 pv_r;
  logic signed [XW-1:0] sx_r, sy_r;
  logic signed [SW-1:0] sxx_r, syy_r, sxy_r;
  logic [CW-1:0]        cnt_r;
  logic                 room;

  // Working values of the end-of-set sequence.
  logic [CW-1:0]       n_r;
  word_t               nn_r;
  word_t               t1_r, dx_r, dy_r, cn_r, mx_r, my_r, cov_r;
  logic [ROOT_W-1:0]   sdx_r, sdy_r;
  logic [CORR_W-1:0]   corr_r;

  word_t     n64, sx64, sy64, sxx64, syy64, sxy64;
  word_t     cn_mag, cov_num, num_mag, qres, qneg, diffv;
  arith_op_t op;
  word_t     opa, opb, ares;
  logic      adone;
  logic      dev_zero;
  logic [2*CW-1:0] nn_full;

  assign room = (cnt_r < CW'(MAX_PAIRS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (cmd.load_out) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else begin
      pv_r <= cmd.accept && room;
      if (cmd.accept && room) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (pv_r) begin
        sx_r  <= sx_r + XW'(px_r);
        sy_r  <= sy_r + XW'(py_r);
        sxx_r <= sxx_r + SW'(pxx_r);
        syy_r <= syy_r + SW'(pyy_r);
        sxy_r <= sxy_r + SW'(pxy_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r  <= sample_x;
    py_r  <= sample_y;
    pxx_r <= sample_x * sample_x;
    pyy_r <= sample_y * sample_y;
    pxy_r <= sample_x * sample_y;
  end

  assign n64   = WORD_W'(n_r);
  assign sx64  = WORD_W'(sx_r);
  assign sy64  = WORD_W'(sy_r);
  assign sxx64 = WORD_W'(sxx_r);
  assign syy64 = WORD_W'(syy_r);
  assign sxy64 = WORD_W'(sxy_r);

  assign cn_mag  = cn_r[WORD_W-1] ? -cn_r : cn_r;
  assign cov_num = cov_r << CORR_SHIFT;
  assign num_mag = cov_num[WORD_W-1] ? -cov_num : cov_num;

  always_comb begin
    op  = ARITH_MUL;
    opa = '0;
    opb = '0;
    case (cmd.step)
      ST_NXX: begin op = ARITH_MUL; opa = n64;  opb = sxx64; end
      ST_SXX: begin op = ARITH_MUL; opa = sx64; opb = sx64;  end
      ST_NYY: begin op = ARITH_MUL; opa = n64;  opb = syy64; end
      ST_SYY: begin op = ARITH_MUL; opa = sy64; opb = sy64;  end
      ST_NXY: begin op = ARITH_MUL; opa = n64;  opb = sxy64; end
      ST_SXY: begin op = ARITH_MUL; opa = sx64; opb = sy64;  end
      ST_MX: begin
        op  = ARITH_DIV;
        opa = sx64[WORD_W-1] ? -sx64 : sx64;
        opb = n64;
      end
      ST_MY: begin
        op  = ARITH_DIV;
        opa = sy64[WORD_W-1] ? -sy64 : sy64;
        opb = n64;
      end
      ST_VX: begin op = ARITH_DIV;  opa = dx_r; opb = nn_r; end
      ST_RX: begin op = ARITH_SQRT; opa = t1_r; end
      ST_VY: begin op = ARITH_DIV;  opa = dy_r; opb = nn_r; end
      ST_RY: begin op = ARITH_SQRT; opa = t1_r; end
      ST_CV: begin op = ARITH_DIV;  opa = cn_mag; opb = nn_r; end
      ST_PD: begin
        op  = ARITH_MUL;
        opa = WORD_W'(sdx_r);
        opb = WORD_W'(sdy_r);
      end
      ST_CR: begin op = ARITH_DIV; opa = num_mag; opb = t1_r; end
      default: begin op = ARITH_MUL; end
    endcase
  end

  pcs_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .op     (op),
    .opa    (opa),
    .opb    (opb),
    .result (ares),
    .done   (adone)
  );

  assign diffv   = t1_r - ares;
  assign qres    = cov_num[WORD_W-1] ? -ares : ares;
  assign qneg    = -qres;
  assign nn_full = cnt_r * cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.begin_set) begin
      n_r  <= cnt_r;
      nn_r <= WORD_W'(nn_full);
    end
    if (adone) begin
      case (cmd.step)
        ST_NXX, ST_NYY, ST_NXY, ST_VX, ST_VY, ST_PD: t1_r <= ares;
        ST_SXX: dx_r <= diffv[WORD_W-1] ? '0 : diffv;
        ST_SYY: dy_r <= diffv[WORD_W-1] ? '0 : diffv;
        ST_SXY: cn_r <= diffv;
        ST_MX:  mx_r <= sx64[WORD_W-1] ? -ares : ares;
        ST_MY:  my_r <= sy64[WORD_W-1] ? -ares : ares;
        ST_RX:  sdx_r <= ares[ROOT_W-1:0];
        ST_RY:  sdy_r <= ares[ROOT_W-1:0];
        ST_CV:  cov_r <= cn_r[WORD_W-1] ? -ares : ares;
        ST_CR: begin
          if (qres[WORD_W-1]) begin
            corr_r <= (qneg > CORR_ONE) ? CORR_W'(-CORR_ONE) : qres[CORR_W-1:0];
          end else begin
            corr_r <= (qres > CORR_ONE) ? CORR_ONE[CORR_W-1:0] : qres[CORR_W-1:0];
          end
        end
        default: t1_r <= t1_r;
      endcase
    end
  end

  assign dev_zero = (sdx_r == '0) || (sdy_r == '0);

  assign status.arith_done = adone;
  assign status.n_zero     = (n_r == '0);
  assign status.dev_zero   = dev_zero;

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (n_r == '0) begin
        mean_x        <= '0;
        mean_y        <= '0;
        std_dev_x     <= '0;
        std_dev_y     <= '0;
        covariance_xy <= '0;
        correlation   <= '0;
        pair_count    <= '0;
        stats_error   <= 1'b1;
      end else begin
        mean_x        <= mx_r[MEAN_W-1:0];
        mean_y        <= my_r[MEAN_W-1:0];
        std_dev_x     <= sdx_r[SD_W-1:0];
        std_dev_y     <= sdy_r[SD_W-1:0];
        covariance_xy <= cov_r[COV_W-1:0];
        correlation   <= dev_zero ? '0 : corr_r;
        pair_count    <= COUNT_W'(n_r);
        stats_error   <= dev_zero;
      end
    end
  end

endmodule

FILE: rtl/pcs_ctrl.sv
module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  pcs_status_t status,
  output pcs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_ACC,
    S_FLUSH,
    S_BEGIN,
    S_ISSUE,
    S_WAIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == S_ACC);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  function automatic step_t next_step(step_t s);
    case (s)
      ST_NXX:  next_step = ST_SXX;
      ST_SXX:  next_step = ST_NYY;
      ST_NYY:  next_step = ST_SYY;
      ST_SYY:  next_step = ST_NXY;
      ST_NXY:  next_step = ST_SXY;
      ST_SXY:  next_step = ST_MX;
      ST_MX:   next_step = ST_MY;
      ST_MY:   next_step = ST_VX;
      ST_VX:   next_step = ST_RX;
      ST_RX:   next_step = ST_VY;
      ST_VY:   next_step = ST_RY;
      ST_RY:   next_step = ST_CV;
      ST_CV:   next_step = ST_PD;
      ST_PD:   next_step = ST_CR;
      default: next_step = ST_NXX;
    endcase
  endfunction

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.accept    = accept;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_ACC: begin
        if (accept && in_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_BEGIN;
      end
      S_BEGIN: begin
        cmd.begin_set = 1'b1;
        step_nxt      = ST_NXX;
        state_nxt     = S_ISSUE;
      end
      S_ISSUE: begin
        // Drop every step of an empty set, and the correlation steps when a deviation is zero.
        if (status.n_zero || (step_r == ST_PD && status.dev_zero)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.arith_done) begin
          if (step_r == ST_CR) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt  = next_step(step_r);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      step_r      <= ST_NXX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/pearson_correlation_stats_core.sv
// Pearson correlation statistics over a set of (x, y) sample pairs.
// Input channel: one word per pair (in_sample_x, in_sample_y, signed
// fixed point), in_last_sample set on the final pair of a set. Words are
// taken one per cycle while loading; pairs past MAX_PAIRS are dropped but
// a last flag on them still closes the set.
// Result channel: one word per set with means, floor-root deviations,
// covariance, correlation (Q1.14, saturated), pair count and error flag.
// End-of-set work: when a set closes, the single shared serial unit runs
// seven multiplies, six divides and two roots, one after another, each
// issued and written back in turn; an empty set skips them all and a zero
// deviation skips the last two. in_ready stays low during it.
// Throughput: one pair per cycle while loading; a new set is not taken
// until the previous set has finished its end-of-set work.
// The result sits in an output register; loading of the next set starts
// at once while it waits. If the receiver still holds the previous result
// when a new set finishes, the block holds its finished set until the
// output register frees up.
// Reset (rst_n low, synchronous) clears the sums, the count and the
// controller; no result is pending afterwards.
module pearson_correlation_stats_core
  import pcs_pkg::*;
#(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [MEAN_W-1:0]      out_mean_x,
  output logic signed [MEAN_W-1:0]      out_mean_y,
  output logic [SD_W-1:0]               out_std_dev_x,
  output logic [SD_W-1:0]               out_std_dev_y,
  output logic signed [COV_W-1:0]       out_covariance_xy,
  output logic signed [CORR_W-1:0]      out_correlation,
  output logic [COUNT_W-1:0]            out_pair_count,
  output logic                          out_stats_error
);

  pcs_cmd_t    cmd;
  pcs_status_t status;

  // Controller: handshakes, step sequencing, output slot.
  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_sample),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: running sums, shared serial unit, result word register.
  pcs_datapath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .sample_x      (in_sample_x),
    .sample_y      (in_sample_y),
    .mean_x        (out_mean_x),
    .mean_y        (out_mean_y),
    .std_dev_x     (out_std_dev_x),
    .std_dev_y     (out_std_dev_y),
    .covariance_xy (out_covariance_xy),
    .correlation   (out_correlation),
    .pair_count    (out_pair_count),
    .stats_error   (out_stats_error)
  );

endmodule

FILE: test/tb_pearson_correlation_stats_core.sv
module tb_pearson_correlation_stats_core;
  import pcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAIRS   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int CYCLE_LIMIT = 2000000;
  // Give the end-of-set work room before the final verdict.
  localparam int SETTLE_CYCLES = 2000;

  // One result word as the block should present it.
  typedef struct {
    logic signed [MEAN_W-1:0]  mean_x;
    logic signed [MEAN_W-1:0]  mean_y;
    logic [SD_W-1:0]           sd_x;
    logic [SD_W-1:0]           sd_y;
    logic signed [COV_W-1:0]   cov;
    logic signed [CORR_W-1:0]  corr;
    logic [COUNT_W-1:0]        count;
    logic                      err;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_x = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_y = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [MEAN_W-1:0] out_mean_x, out_mean_y;
  logic [SD_W-1:0]          out_std_dev_x, out_std_dev_y;
  logic signed [COV_W-1:0]  out_covariance_xy;
  logic signed [CORR_W-1:0] out_correlation;
  logic [COUNT_W-1:0]       out_pair_count;
  logic                     out_stats_error;

  pearson_correlation_stats_core #(
    .MAX_PAIRS(MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (.*);

  always #6 clk = ~clk;

  // Running sums mirrored from the block, kept modulo 2^64.
  bit [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy, acc_n;
  stats_t stats_due[$];

  int  fails = 0;
  int  cycle = 0;
  int  hold_until = 0;      // receiver holds off while cycle is below this
  bit  tx_eager = 1'b0;     // sender: no gaps
  bit  rx_eager = 1'b0;     // receiver: ready outside hold-off and pending stalls
  int  rx_stall = 0;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Signed quotient of a two's complement value by a positive divisor,
  // truncated toward zero.
  function automatic bit [63:0] quot_trunc(bit [63:0] num, bit [63:0] den);
    bit [63:0] mag;
    bit [63:0] q;
    if (den == 0) return 64'd0;
    mag = num[63] ? -num : num;
    q = mag / den;
    return num[63] ? -q : q;
  endfunction

  // Floor square root, built up one result bit at a time from the top.
  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_acc();
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_n = 0;
  endfunction

  // Fold one accepted pair into the sums; on the last pair queue the result.
  function automatic void accumulate_pair(logic signed [15:0] x, logic signed [15:0] y,
                                          logic last);
    bit signed [63:0] xs;
    bit signed [63:0] ys;
    bit [63:0] nn, dx, dy, cn, sdx, sdy, cov, corr, mx, my;
    stats_t s;
    xs = 64'(x);
    ys = 64'(y);
    if (acc_n < MAX_PAIRS) begin
      acc_x  += xs;
      acc_y  += ys;
      acc_xx += xs * xs;
      acc_yy += ys * ys;
      acc_xy += xs * ys;
      acc_n  += 1;
    end
    if (!last) return;
    if (acc_n == 0) begin
      s = '{default: '0};
      s.err = 1'b1;
    end else begin
      nn = acc_n * acc_n;
      dx = acc_n * acc_xx - acc_x * acc_x;
      dy = acc_n * acc_yy - acc_y * acc_y;
      if (dx[63]) dx = 0;
      if (dy[63]) dy = 0;
      cn = acc_n * acc_xy - acc_x * acc_y;
      sdx = floor_root(dx / nn);
      sdy = floor_root(dy / nn);
      cov = quot_trunc(cn, nn);
      s.err = (sdx == 0) || (sdy == 0);
      if (s.err) begin
        corr = 0;
      end else begin
        corr = quot_trunc(cov * 64'd16384, sdx * sdy);
        // Floored deviations can push the ratio past one; clamp it.
        if (corr[63]) begin
          if (-corr > 64'd16384) corr = -64'd16384;
        end else if (corr > 64'd16384) begin
          corr = 64'd16384;
        end
      end
      mx = quot_trunc(acc_x, acc_n);
      my = quot_trunc(acc_y, acc_n);
      s.mean_x = mx[15:0];
      s.mean_y = my[15:0];
      s.sd_x   = sdx[15:0];
      s.sd_y   = sdy[15:0];
      s.cov    = cov[31:0];
      s.corr   = corr[15:0];
      s.count  = acc_n[10:0];
    end
    stats_due.push_back(s);
    clear_acc();
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_eager || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one pair and hold it until the block takes the word.
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_x    <= x;
    in_sample_y    <= y;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    accumulate_pair(x, y, last);
  endtask

  // Drop valid and wait until every queued result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random ready with occasional stalls, or a long hold-off.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (cycle < hold_until) begin
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_eager) begin
      out_ready <= 1'b1;
    end else begin
      if (r < 3) rx_stall <= $urandom_range(20, 200);
      out_ready <= (r >= 30);
    end
  end

  // Compare each taken result word with the oldest expectation.
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_valid && out_ready) begin
      if (stats_due.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = stats_due.pop_front();
        if (out_mean_x !== e.mean_x) begin
          $error("mean_x expected %0d got %0d", e.mean_x, out_mean_x); fails++;
        end
        if (out_mean_y !== e.mean_y) begin
          $error("mean_y expected %0d got %0d", e.mean_y, out_mean_y); fails++;
        end
        if (out_std_dev_x !== e.sd_x) begin
          $error("std_dev_x expected %0d got %0d", e.sd_x, out_std_dev_x); fails++;
        end
        if (out_std_dev_y !== e.sd_y) begin
          $error("std_dev_y expected %0d got %0d", e.sd_y, out_std_dev_y); fails++;
        end
        if (out_covariance_xy !== e.cov) begin
          $error("covariance_xy expected %0d got %0d", e.cov, out_covariance_xy); fails++;
        end
        if (out_correlation !== e.corr) begin
          $error("correlation expected %0d got %0d", e.corr, out_correlation); fails++;
        end
        if (out_pair_count !== e.count) begin
          $error("pair_count expected %0d got %0d", e.count, out_pair_count); fails++;
        end
        if (out_stats_error !== e.err) begin
          $error("stats_error expected %0d got %0d", e.err, out_stats_error); fails++;
        end
      end
    end
  end

  // Hand-picked sets: extremes, one-pair set, constant data, exact
  // positive and negative correlation, all zero samples.
  task automatic test_directed();
    send_pair(16'sh7FFF, -16'sh8000, 1'b1);            // one pair: zero deviation
    send_pair(-16'sh8000, -16'sh8000, 1'b0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);              // extremes, perfect match
    for (int i = 0; i < 5; i++) send_pair(16'(i * 300 - 700), 16'(i * 300 - 700), i == 4);
    for (int i = 0; i < 4; i++) send_pair(16'(i * 97 - 5), 16'(-i * 211 + 3), i == 3);
    for (int i = 0; i < 3; i++) send_pair(16'sh0100, 16'(i * 50 - 77), i == 2);
    send_pair(16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b1);              // all zero: error
    send_pair(-16'sd3, -16'sd7, 1'b0);
    send_pair(-16'sd2, 16'sd1, 1'b1);                   // negative means truncate
    drain();
  endtask

  // Random set of the given length with varied data shapes.
  task automatic random_set(int len);
    int mode;
    int k;
    logic signed [15:0] x, y;
    mode = $urandom_range(0, 3);
    k = $urandom_range(1, 7);
    for (int i = 0; i < len; i++) begin
      x = 16'($urandom);
      case (mode)
        0: y = 16'($urandom);
        1: begin
          x = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
          y = 16'(x * k + $signed(16'($urandom_range(0, 63))) - 16'sd32);
        end
        2: begin
          x = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
          y = -x + $signed(16'($urandom_range(0, 15))) - 16'sd8;
        end
        default: y = x;
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 450) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      tx_eager = ($urandom_range(0, 4) == 0);
      rx_eager = ($urandom_range(0, 4) == 0);
      random_set(len);
      sent += len;
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    drain();
  endtask

  // Hold the receiver off while several sets complete, so the block fills
  // its output register and its held set and stalls the input.
  task automatic test_backpressure();
    hold_until = cycle + 5000;
    tx_eager = 1'b1;
    for (int s = 0; s < 4; s++) random_set($urandom_range(2, 6));
    tx_eager = 1'b0;
    drain();
  endtask

  // One set that fills to MAX_PAIRS and runs past it, with the last flag
  // on a dropped pair.
  task automatic test_overflow();
    tx_eager = 1'b1;
    for (int i = 0; i < MAX_PAIRS + 6; i++)
      send_pair(16'($urandom), 16'($urandom), i == MAX_PAIRS + 5);
    tx_eager = 1'b0;
    drain();
  endtask

  initial begin
    clear_acc();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_overflow();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && stats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
